// File: hw/rtl/sobel_pkg.sv
// sobel_pkg: shared types, constants and helpers of the sobel edge threshold stream
// used by sobel_edge_threshold_stream and its checker; no dependencies
`timescale 1ns / 1ps

package sobel_pkg;

  // default frame size limits
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  // register reset values and widths
  localparam int unsigned WIDTH_RST  = 512;
  localparam int unsigned HEIGHT_RST = 512;
  localparam int unsigned THRESH_W   = 11;
  localparam int unsigned MAG_W      = 22;
  localparam logic [MAG_W-1:0] THRESH_SQ_RST = 22'(38 * 38);

  // smallest legal frame side
  localparam int unsigned MIN_SIZE = 2;

  // result codes
  localparam logic [7:0] PIX_EDGE    = 8'd0;
  localparam logic [7:0] PIX_NO_EDGE = 8'd255;

  // item kinds
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // one input transaction
  typedef struct packed {
    logic       action;
    logic [7:0] pixel_value;
  } pix_item_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] edge_pixel;
    logic       end_of_row;
    logic       end_of_frame;
  } res_item_t;

  // clamp a frame side into [MIN_SIZE, maxv]
  function automatic logic [31:0] sat_size(input logic [CFG_DATA_W-1:0] v,
                                           input int unsigned maxv);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 < MIN_SIZE) begin
      return 32'(MIN_SIZE);
    end else if (v32 > maxv) begin
      return maxv;
    end
    return v32;
  endfunction

endpackage

// File: hw/rtl/sobel_edge_threshold_stream.sv
// sobel_edge_threshold_stream: streaming 3x3 sobel edge detector with threshold
// depends on sobel_pkg and sobel_ram
`timescale 1ns / 1ps

// Usage
//   pix channel (pix_valid/pix_ready/pix_data): grey pixels in raster order,
//   action = pixel for frame data, action = flush to drain the last results.
//   res channel (res_valid/res_ready/res_data): one edge decision per pixel,
//   0 = edge, 255 = no edge, with end_of_row / end_of_frame marks.
//   The result for pixel k is caused by transaction k + width + 1, so after the
//   last pixel of a frame width + 1 flush transactions drain it. Flushes inside
//   a frame and pixels during the drain are accepted and dropped.
//   One transaction per cycle while the pipeline is not held. A result reaches
//   res_valid through the window, squaring and compare registers, in that
//   order. The line stores sit in one RAM read one column ahead.
//   Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once and
//   restart the frame; write them only while the block is idle.
//   Reset (rst, synchronous) empties the pipeline and restarts the frame; the
//   registers return to 512 x 512 with threshold 38. Line stores are not cleared.
//   When res_ready is low the pipeline holds; pix_ready drops once every stage
//   holds a result.

module sobel_edge_threshold_stream #(
  parameter int unsigned MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pix_valid,
  output logic                               pix_ready,
  input  sobel_pkg::pix_item_t               pix_data,
  output logic                               res_valid,
  input  logic                               res_ready,
  output sobel_pkg::res_item_t               res_data,
  input  logic                               cfg_we,
  input  logic [sobel_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WL = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HL = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned MW = sobel_pkg::MAG_W;
  localparam int unsigned WIDTH_RST_SAT =
    (sobel_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : sobel_pkg::WIDTH_RST;
  localparam int unsigned HEIGHT_RST_SAT =
    (sobel_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : sobel_pkg::HEIGHT_RST;

  // configuration and position state
  logic [WL-1:0] width_lim;
  logic [HL-1:0] height_lim;
  logic [MW-1:0] thr_sq;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  // window columns, index 0 = top
  logic [2:0][7:0] left_col;
  logic [2:0][7:0] mid_col;

  // pipeline registers
  logic               s1_valid;
  logic signed [10:0] s1_gx;
  logic signed [10:0] s1_gy;
  logic               s1_eor;
  logic               s1_eof;
  logic               s2_valid;
  logic [19:0]        s2_gx2;
  logic [19:0]        s2_gy2;
  logic               s2_eor;
  logic               s2_eof;

  // stage control
  logic out_load;
  logic s2_load;
  logic s1_load;
  logic accept;
  logic take;

  // window stage signals
  logic               row_lt_h;
  logic               row_gt_h;
  logic               emit_a;
  logic               emit_b;
  logic               cfg_restart;
  logic [15:0]        ram_q;
  logic               ram_we;
  logic [CW-1:0]      ram_raddr;
  logic [2:0][7:0]    v_col;
  logic [2:0][7:0]    left_win;
  logic [2:0][7:0]    right_win;
  logic [9:0]         top_sum;
  logic [9:0]         bot_sum;
  logic [9:0]         lft_sum;
  logic [9:0]         rgt_sum;
  logic signed [10:0] gx;
  logic signed [10:0] gy;
  logic [CW:0]        col_inc;
  logic signed [21:0] gx_prod;
  logic signed [21:0] gy_prod;
  logic [MW-1:0]      mag2;
  logic [31:0]        cfg_sat_w;
  logic [31:0]        cfg_sat_h;

  // pipeline advance, bubbles collapse
  assign out_load  = !res_valid || res_ready;
  assign s2_load   = !s2_valid || out_load;
  assign s1_load   = !s1_valid || s2_load;
  assign pix_ready = s1_load && !rst;
  assign accept    = pix_valid && pix_ready;

  // line stores: upper in the high byte, lower in the low byte
  sobel_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(col),
    .wdata({ram_q[7:0], pix_data.pixel_value}),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // window stage: neighborhood, gradients and next position
  always_comb begin
    row_lt_h = 32'(row) < 32'(height_lim);
    row_gt_h = 32'(row) > 32'(height_lim);
    // pixels only inside the frame, flushes only while draining
    take = accept && ((pix_data.action == sobel_pkg::ACT_FLUSH) == !row_lt_h);

    v_col[0] = (row == RW'(1)) ? ram_q[7:0] : ram_q[15:8];
    v_col[1] = ram_q[7:0];
    v_col[2] = row_lt_h ? pix_data.pixel_value : ram_q[7:0];

    emit_a = (col != '0) && (row != '0) && !row_gt_h;
    emit_b = (col == '0) && (32'(row) >= 32'(sobel_pkg::MIN_SIZE));

    // left border replicates the center column, right border likewise
    left_win  = (emit_a && (col == CW'(1))) ? mid_col : left_col;
    right_win = emit_a ? v_col : mid_col;

    top_sum = 10'(left_win[0]) + {1'b0, mid_col[0], 1'b0} + 10'(right_win[0]);
    bot_sum = 10'(left_win[2]) + {1'b0, mid_col[2], 1'b0} + 10'(right_win[2]);
    lft_sum = 10'(left_win[0]) + {1'b0, left_win[1], 1'b0} + 10'(left_win[2]);
    rgt_sum = 10'(right_win[0]) + {1'b0, right_win[1], 1'b0} + 10'(right_win[2]);
    gy = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
    gx = $signed({1'b0, rgt_sum}) - $signed({1'b0, lft_sum});

    // raster position advance, restart after the drain
    col_inc = {1'b0, col} + (CW + 1)'(1);
    if (row_gt_h) begin
      col_next = '0;
      row_next = '0;
    end else if (32'(col_inc) >= 32'(width_lim)) begin
      col_next = '0;
      row_next = row + RW'(1);
    end else begin
      col_next = col_inc[CW-1:0];
      row_next = row;
    end

    // only writes to an existing register restart the frame
    cfg_restart = cfg_we && ((cfg_index == sobel_pkg::CFG_IMAGE_WIDTH) ||
                             (cfg_index == sobel_pkg::CFG_IMAGE_HEIGHT) ||
                             (cfg_index == sobel_pkg::CFG_EDGE_THRESHOLD));

    // read one column ahead so data is ready for the next transaction
    ram_we = take && row_lt_h;
    if (rst || cfg_restart) begin
      ram_raddr = '0;
    end else if (take) begin
      ram_raddr = col_next;
    end else begin
      ram_raddr = col;
    end

    cfg_sat_w = sobel_pkg::sat_size(cfg_wdata, MAX_WIDTH);
    cfg_sat_h = sobel_pkg::sat_size(cfg_wdata, MAX_HEIGHT);
  end

  // configuration, position and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      width_lim  <= WL'(WIDTH_RST_SAT);
      height_lim <= HL'(HEIGHT_RST_SAT);
      thr_sq     <= sobel_pkg::THRESH_SQ_RST;
      col        <= '0;
      row        <= '0;
      left_col   <= '0;
      mid_col    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sobel_pkg::CFG_IMAGE_WIDTH: begin
          width_lim <= cfg_sat_w[WL-1:0];
          col       <= '0;
          row       <= '0;
        end
        sobel_pkg::CFG_IMAGE_HEIGHT: begin
          height_lim <= cfg_sat_h[HL-1:0];
          col        <= '0;
          row        <= '0;
        end
        sobel_pkg::CFG_EDGE_THRESHOLD: begin
          thr_sq <= MW'(cfg_wdata[sobel_pkg::THRESH_W-1:0])
                    * MW'(cfg_wdata[sobel_pkg::THRESH_W-1:0]);
          col    <= '0;
          row    <= '0;
        end
        default: begin
        end
      endcase
    end else if (take) begin
      col <= col_next;
      row <= row_next;
      if (col != '0) begin
        left_col <= mid_col;
      end
      mid_col <= v_col;
    end
  end

  // squaring and compare stages
  assign gx_prod = s1_gx * s1_gx;
  assign gy_prod = s1_gy * s1_gy;
  assign mag2    = MW'(s2_gx2) + MW'(s2_gy2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= take && (emit_a || emit_b);
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (out_load) begin
        res_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_gx  <= gx;
      s1_gy  <= gy;
      s1_eor <= emit_b;
      s1_eof <= emit_b && row_gt_h;
    end
    if (s2_load) begin
      s2_gx2 <= gx_prod[19:0];
      s2_gy2 <= gy_prod[19:0];
      s2_eor <= s1_eor;
      s2_eof <= s1_eof;
    end
    if (out_load) begin
      res_data.edge_pixel   <= (mag2 > thr_sq) ? sobel_pkg::PIX_EDGE : sobel_pkg::PIX_NO_EDGE;
      res_data.end_of_row   <= s2_eor;
      res_data.end_of_frame <= s2_eof;
    end
  end

endmodule

// File: hw/rtl/sobel_ram.sv
// sobel_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module sobel_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/sobel_chk.sv
// sobel_chk: port-level assertions for sobel_edge_threshold_stream, bound to it
// depends on sobel_pkg
`timescale 1ns / 1ps

module sobel_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              pix_valid,
  input logic                              pix_ready,
  input sobel_pkg::pix_item_t              pix_data,
  input logic                              res_valid,
  input logic                              res_ready,
  input sobel_pkg::res_item_t              res_data,
  input logic                              cfg_we,
  input logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // a stalled result transaction holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // frame end is always also a row end
  a_eof_eor: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.end_of_frame |-> res_data.end_of_row)
    else $error("end_of_frame without end_of_row");

  // only the two result codes appear
  a_codes: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.edge_pixel == sobel_pkg::PIX_EDGE ||
                   res_data.edge_pixel == sobel_pkg::PIX_NO_EDGE))
    else $error("illegal edge_pixel code");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result pending after reset");

endmodule

bind sobel_edge_threshold_stream sobel_chk u_sobel_chk (.*);

// File: bench/tb_sobel_edge_threshold_stream.sv
// tb_sobel_edge_threshold_stream: self-checking bench for the streaming sobel edge detector
// predicts every edge decision and end mark from its own window model and checks each one
// depends on sobel_pkg and sobel_edge_threshold_stream
`timescale 1ns / 1ps

module tb_sobel_edge_threshold_stream;
  import sobel_pkg::*;

  localparam int unsigned LINE_LEN      = MAX_WIDTH_DEF;
  localparam int unsigned THRESH_RST    = 38;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 520;
  localparam int unsigned RUN_LIMIT_NS  = 20_000_000;

  // index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {TEX_NOISE, TEX_BINARY, TEX_SMOOTH} texture_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   pix_valid = 1'b0;
  logic                   pix_ready;
  pix_item_t              pix_data  = '0;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  res_item_t              res_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // register copies and window state of the edge predictor
  logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(WIDTH_RST);
  logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(HEIGHT_RST);
  logic [THRESH_W-1:0]   thresh_reg = THRESH_W'(THRESH_RST);
  bit [7:0]              upper_line [LINE_LEN];
  bit [7:0]              lower_line [LINE_LEN];
  bit [7:0]              left_col [3];
  bit [7:0]              mid_col [3];
  int unsigned           cur_col = 0;
  int unsigned           cur_row = 0;

  pix_item_t   pix_items [$];
  res_item_t   edge_map_due [$];
  bit          pix_taken      = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  sobel_edge_threshold_stream uut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned clamp_side(input logic [CFG_DATA_W-1:0] raw,
                                             input int unsigned limit);
    int unsigned side;
    side = raw;
    if (side < MIN_SIZE) begin
      side = MIN_SIZE;
    end else if (side > limit) begin
      side = limit;
    end
    return side;
  endfunction

  task automatic flag_error(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // advance the window by one accepted transaction and queue the edge decision it yields
  task automatic predict_edge_result(input pix_item_t it);
    int unsigned wid, hgt, x, row, cr, cc;
    bit [7:0]    col_new [3];
    int          wv [9];
    int          gx, gy, mag2, thr;
    bit          emit;
    res_item_t   r;
    wid  = clamp_side(width_reg, MAX_WIDTH_DEF);
    hgt  = clamp_side(height_reg, MAX_HEIGHT_DEF);
    x    = cur_col;
    row  = cur_row;
    emit = 1'b0;
    // pixels during the drain and flushes inside the frame are dropped
    if (it.action == ACT_PIXEL && row >= hgt) return;
    if (it.action == ACT_FLUSH && row < hgt) return;

    // incoming column: top, middle, bottom
    col_new[0] = upper_line[x];
    col_new[1] = lower_line[x];
    if (row < hgt) begin
      col_new[2]    = it.pixel_value;
      upper_line[x] = col_new[1];
      lower_line[x] = it.pixel_value;
    end else begin
      col_new[2] = col_new[1];
    end
    // top border replicates the first row
    if (row == 1) begin
      col_new[0] = col_new[1];
    end

    // window columns: left, centre, right (index = column * 3 + row)
    if (x >= 1 && row >= 1 && row <= hgt) begin
      for (int i = 0; i < 3; i++) begin
        wv[i]     = (x == 1) ? mid_col[i] : left_col[i];
        wv[3 + i] = mid_col[i];
        wv[6 + i] = col_new[i];
      end
      cr   = row - 1;
      cc   = x - 1;
      emit = 1'b1;
    end else if (x == 0 && row >= 2) begin
      // last column of the row above, right border replicated
      for (int i = 0; i < 3; i++) begin
        wv[i]     = left_col[i];
        wv[3 + i] = mid_col[i];
        wv[6 + i] = mid_col[i];
      end
      cr   = row - 2;
      cc   = wid - 1;
      emit = 1'b1;
    end

    if (emit) begin
      gy   = (wv[2] + 2 * wv[5] + wv[8]) - (wv[0] + 2 * wv[3] + wv[6]);
      gx   = (wv[6] + 2 * wv[7] + wv[8]) - (wv[0] + 2 * wv[1] + wv[2]);
      mag2 = gx * gx + gy * gy;
      thr  = thresh_reg;
      r.edge_pixel   = (mag2 > thr * thr) ? PIX_EDGE : PIX_NO_EDGE;
      r.end_of_row   = (cc == wid - 1);
      r.end_of_frame = (cc == wid - 1) && (cr == hgt - 1);
      edge_map_due.push_back(r);
    end

    if (x != 0) begin
      left_col = mid_col;
    end
    mid_col = col_new;

    // position update, frame restarts after the final drain transaction
    if (row >= hgt + 1) begin
      cur_col = 0;
      cur_row = 0;
    end else begin
      x++;
      if (x >= wid) begin
        x = 0;
        row++;
      end
      cur_col = x;
      cur_row = row;
    end
  endtask

  // input driver: at each falling edge, hold an untaken transaction, else offer a new one or idle
  always @(negedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || pix_taken) begin
      if (pix_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pix_data  <= pix_items.pop_front();
        pix_valid <= 1'b1;
      end else begin
        pix_valid <= 1'b0;
      end
    end
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: check results, then predict from the accepted input
  always @(posedge clk) begin : watch_ports
    res_item_t want;
    pix_taken = 1'b0;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (edge_map_due.size() == 0) begin
          flag_error("result with nothing pending, edge_pixel", res_data.edge_pixel, 'x);
        end else begin
          want = edge_map_due.pop_front();
          if (res_data.edge_pixel !== want.edge_pixel) begin
            flag_error("edge_pixel", res_data.edge_pixel, want.edge_pixel);
          end
          if (res_data.end_of_row !== want.end_of_row) begin
            flag_error("end_of_row", res_data.end_of_row, want.end_of_row);
          end
          if (res_data.end_of_frame !== want.end_of_frame) begin
            flag_error("end_of_frame", res_data.end_of_frame, want.end_of_frame);
          end
        end
      end
      if (pix_valid && pix_ready) begin
        pix_taken = 1'b1;
        predict_edge_result(pix_data);
      end
    end
  end

  task automatic push_item(input logic act, input int unsigned value);
    pix_items.push_back(pix_item_t'{action: act, pixel_value: 8'(value)});
  endtask

  // hold off until every transaction is taken and every result has come out
  // checked at rising edges, where the driven inputs are settled
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (pix_items.size() != 0 || pix_valid || edge_map_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one register write; only called while the block is idle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    case (idx)
      CFG_IMAGE_WIDTH: begin
        width_reg = CFG_DATA_W'(value);
      end
      CFG_IMAGE_HEIGHT: begin
        height_reg = CFG_DATA_W'(value);
      end
      CFG_EDGE_THRESHOLD: begin
        thresh_reg = THRESH_W'(value);
      end
      default: begin
      end
    endcase
    if (idx != CFG_UNUSED) begin
      cur_col = 0;
      cur_row = 0;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // 2x2 frame with its drain, optionally with dropped transactions mixed in
  task automatic queue_tiny_frame(input bit noisy, input bit [7:0] p0, input bit [7:0] p1,
                                  input bit [7:0] p2, input bit [7:0] p3);
    if (noisy) begin
      push_item(ACT_FLUSH, 8'hA5);
    end
    push_item(ACT_PIXEL, p0);
    push_item(ACT_PIXEL, p1);
    push_item(ACT_PIXEL, p2);
    push_item(ACT_PIXEL, p3);
    push_item(ACT_FLUSH, 8'h00);
    if (noisy) begin
      push_item(ACT_PIXEL, 8'h5A);
    end
    push_item(ACT_FLUSH, 8'hFF);
    push_item(ACT_FLUSH, 8'h00);
  endtask

  // queue the first keep pixels of a frame, plus the drain if the frame is complete
  task automatic queue_frame(input int unsigned keep, input int unsigned pause_at,
                             input bit noisy, input texture_t tex,
                             output int unsigned taken);
    int unsigned wid, hgt;
    int          level;
    wid   = clamp_side(width_reg, MAX_WIDTH_DEF);
    hgt   = clamp_side(height_reg, MAX_HEIGHT_DEF);
    level = $urandom_range(255);
    taken = 0;
    for (int unsigned k = 0; k < keep; k++) begin
      // sender pauses mid-frame until the block has run dry
      if (k == pause_at) begin
        wait_idle();
        if ($urandom_range(1) == 1) begin
          write_reg(CFG_UNUSED, $urandom);
        end
      end
      if (noisy && $urandom_range(9) == 0) begin
        push_item(ACT_FLUSH, $urandom);
      end
      case (tex)
        TEX_BINARY: begin
          level = ($urandom_range(1) == 1) ? 255 : 0;
        end
        TEX_SMOOTH: begin
          level += int'($urandom_range(24)) - 12;
          if (level < 0) begin
            level = 0;
          end else if (level > 255) begin
            level = 255;
          end
        end
        default: begin
          level = $urandom_range(255);
        end
      endcase
      push_item(ACT_PIXEL, level);
      taken++;
    end
    if (keep == wid * hgt) begin
      for (int unsigned k = 0; k <= wid; k++) begin
        if (noisy && $urandom_range(7) == 0) begin
          push_item(ACT_PIXEL, $urandom);
        end
        push_item(ACT_FLUSH, $urandom);
        taken++;
      end
    end
  endtask

  // mostly small frames, some saturated sizes, thresholds on both sides of typical gradients
  task automatic pick_config();
    int unsigned pick;
    pick = $urandom_range(99);
    write_reg(CFG_IMAGE_WIDTH, (pick < 8) ? $urandom_range(1) :
                               (pick < 20) ? $urandom_range(40, 13) : $urandom_range(12, 2));
    pick = $urandom_range(99);
    write_reg(CFG_IMAGE_HEIGHT, (pick < 8) ? $urandom_range(1) : $urandom_range(6, 2));
    pick = $urandom_range(99);
    write_reg(CFG_EDGE_THRESHOLD, (pick < 45) ? $urandom_range(80) :
                                  (pick < 90) ? $urandom_range(1443) :
                                  $urandom_range(4095, 1443));
  endtask

  // stimulus
  initial begin
    int unsigned counted, taken, total, keep, pause_at;
    bit          must_write;
    counted = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sizes and threshold: part of a 512 wide frame, abandoned by the next write
    queue_frame(530, 530, 1'b1, TEX_SMOOTH, taken);
    wait_idle();

    // 2x2 frames from saturated sizes, threshold zero, dropped flush and pixel
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 1);
    write_reg(CFG_EDGE_THRESHOLD, 0);
    queue_tiny_frame(1'b1, 8'd0, 8'd255, 8'd255, 8'd0);
    // gradient of exactly 1020 everywhere: equal is not an edge, one below is
    wait_idle();
    write_reg(CFG_EDGE_THRESHOLD, 1020);
    queue_tiny_frame(1'b0, 8'd0, 8'd0, 8'd255, 8'd255);
    wait_idle();
    write_reg(CFG_EDGE_THRESHOLD, 1019);
    queue_tiny_frame(1'b0, 8'd0, 8'd0, 8'd255, 8'd255);

    // height above the limit saturates: a tall two-column frame, abandoned part way
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 2);
    write_reg(CFG_IMAGE_HEIGHT, 4095);
    write_reg(CFG_EDGE_THRESHOLD, 40);
    queue_frame(64, 0, 1'b0, TEX_SMOOTH, taken);

    // random frames over four flow-control phases
    must_write = 1'b1;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      while (counted < RANDOM_ITEMS * (p + 1) / 4) begin
        // an abandoned frame always gets a fresh configuration
        if (must_write || $urandom_range(99) < 70) begin
          wait_idle();
          pick_config();
        end
        total    = clamp_side(width_reg, MAX_WIDTH_DEF) * clamp_side(height_reg, MAX_HEIGHT_DEF);
        keep     = ($urandom_range(99) < 10) ? $urandom_range(total - 1, 1) : total;
        pause_at = ($urandom_range(99) < 10) ? $urandom_range(total - 1, 1) : total;
        queue_frame(keep, pause_at, $urandom_range(99) < 30, texture_t'($urandom_range(2)),
                    taken);
        counted += taken;
        must_write = (keep != total);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
